@@ hw/rtl/pcft_pkg.sv @@
package pcft_pkg;

  // Width of every coordinate field and of the configuration write data.
  localparam int unsigned DATA_W = 32;
  // Width of the two radius registers.
  localparam int unsigned RAD_W = 31;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 3;
  // Default number of significant coordinate bits.
  localparam int unsigned DEFAULT_COORD_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_APEX_X      = 3'd0,
    CFG_APEX_Y      = 3'd1,
    CFG_APEX_Z      = 3'd2,
    CFG_BASE_X      = 3'd3,
    CFG_BASE_Y      = 3'd4,
    CFG_BASE_Z      = 3'd5,
    CFG_APEX_RADIUS = 3'd6,
    CFG_BASE_RADIUS = 3'd7
  } cfg_idx_e;

endpackage

@@ hw/rtl/point_in_cone_frustum_test.sv @@
// Throughput: one point per clock cycle, sustained; busy_o never rises and no result is dropped.
// The latency is set by three bit-per-stage chains: the square roots, the projection divider
// and the radius divider, each one result bit per pipeline stage.
// Reset (rst_ni low, asynchronous) clears all configuration registers and all valid bits.
module point_in_cone_frustum_test #(
  parameter int unsigned COORD_WIDTH = pcft_pkg::DEFAULT_COORD_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [pcft_pkg::DATA_W-1:0]  point_x_i,
  input  logic signed [pcft_pkg::DATA_W-1:0]  point_y_i,
  input  logic signed [pcft_pkg::DATA_W-1:0]  point_z_i,
  input  logic                               cfg_we_i,
  input  logic [pcft_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pcft_pkg::DATA_W-1:0]         cfg_wdata_i,
  output logic                               done_o,
  output logic                               inside_res_o,
  output logic [pcft_pkg::DATA_W-1:0]         apex_distance_o,
  output logic                               degenerate_o
);

  // Significant coordinate bits; higher bits of the 32-bit fields are ignored.
  localparam int unsigned CB  = (COORD_WIDTH < pcft_pkg::DATA_W) ? COORD_WIDTH
                                                                  : pcft_pkg::DATA_W;
  // A difference of two coordinates is one bit wider; its magnitude fits in CB bits.
  localparam int unsigned DW  = CB + 1;
  localparam int unsigned MW  = CB;
  // Squared magnitudes and the three-term sums over x, y and z.
  localparam int unsigned PW  = 2 * MW;
  localparam int unsigned SW  = PW + 2;
  // A square root of an SW-bit value, and also the projection, fits in RTW bits.
  localparam int unsigned RTW = MW + 1;
  localparam int unsigned RAD_W = pcft_pkg::RAD_W;
  // Numerator of the radius interpolation: projection times radius difference.
  localparam int unsigned QW  = RTW + RAD_W;
  localparam int unsigned RW2 = (SW > QW) ? SW : QW;
  // Length of the last segment, which runs the axis-distance root and the radius divider.
  localparam int unsigned LD  = (RTW > RAD_W) ? RTW : RAD_W;
  localparam int unsigned XW  = (RTW > RAD_W + 1) ? RTW : RAD_W + 1;
  localparam int unsigned LAT = 9 + 2 * RTW + LD;
  localparam int unsigned DATA_W = pcft_pkg::DATA_W;

  function automatic logic signed [DW-1:0] sext(logic [DATA_W-1:0] v);
    return DW'(signed'(v[CB-1:0]));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration registers; the stages that use them read them directly. The user must
  // change them only while no point is in flight. The block itself does not enforce this.
  // ---------------------------------------------------------------------------------------
  logic [DATA_W-1:0] apex_q [3];
  logic [DATA_W-1:0] base_q [3];
  logic [RAD_W-1:0]  rad_a_q, rad_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        apex_q[i] <= '0;
        base_q[i] <= '0;
      end
      rad_a_q <= '0;
      rad_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pcft_pkg::cfg_idx_e'(cfg_idx_i))
        pcft_pkg::CFG_APEX_X:      apex_q[0] <= cfg_wdata_i;
        pcft_pkg::CFG_APEX_Y:      apex_q[1] <= cfg_wdata_i;
        pcft_pkg::CFG_APEX_Z:      apex_q[2] <= cfg_wdata_i;
        pcft_pkg::CFG_BASE_X:      base_q[0] <= cfg_wdata_i;
        pcft_pkg::CFG_BASE_Y:      base_q[1] <= cfg_wdata_i;
        pcft_pkg::CFG_BASE_Z:      base_q[2] <= cfg_wdata_i;
        pcft_pkg::CFG_APEX_RADIUS: rad_a_q   <= cfg_wdata_i[RAD_W-1:0];
        pcft_pkg::CFG_BASE_RADIUS: rad_b_q   <= cfg_wdata_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls: the receiver takes every result, so a beat is always taken.
  assign busy_o = 1'b0;

  // Valid bits, one per pipeline stage; bit LAT belongs to the output register.
  logic [LAT:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-1:1], start_i & ~busy_o};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: axis vector A = base - apex and point offset D = point - apex.
  // ---------------------------------------------------------------------------------------
  logic [DATA_W-1:0]    pt [3];
  logic signed [DW-1:0] ax_d [3], dx_d [3];
  logic signed [DW-1:0] ax_q [3], dx_q [3];

  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    for (int i = 0; i < 3; i++) begin
      ax_d[i] = sext(base_q[i]) - sext(apex_q[i]);
      dx_d[i] = sext(pt[i]) - sext(apex_q[i]);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: nine magnitude products. The dot product is kept as a positive and a negative
  // sum of magnitudes so that every product stays unsigned.
  // ---------------------------------------------------------------------------------------
  logic [MW-1:0] am [3], dm [3];
  logic [PW-1:0] aa_d [3], dd_d [3], ad_d [3];
  logic [2:0]    adn_d;
  logic [PW-1:0] aa_q [3], dd_q [3], ad_q [3];
  logic [2:0]    adn_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      am[i]    = ax_q[i][DW-1] ? MW'(-ax_q[i]) : MW'(ax_q[i]);
      dm[i]    = dx_q[i][DW-1] ? MW'(-dx_q[i]) : MW'(dx_q[i]);
      aa_d[i]  = PW'(am[i]) * PW'(am[i]);
      dd_d[i]  = PW'(dm[i]) * PW'(dm[i]);
      ad_d[i]  = PW'(am[i]) * PW'(dm[i]);
      adn_d[i] = ax_q[i][DW-1] ^ dx_q[i][DW-1];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: |A|^2, |D|^2 and the two halves of A.D.
  // ---------------------------------------------------------------------------------------
  logic [SW-1:0] h2_d, dd2_d, spos_d, sneg_d;
  logic [SW-1:0] h2_q, dd2_q, spos_q, sneg_q;

  always_comb begin
    h2_d   = SW'(aa_q[0]) + SW'(aa_q[1]) + SW'(aa_q[2]);
    dd2_d  = SW'(dd_q[0]) + SW'(dd_q[1]) + SW'(dd_q[2]);
    spos_d = '0;
    sneg_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (adn_q[i]) begin
        sneg_d = sneg_d + SW'(ad_q[i]);
      end else begin
        spos_d = spos_d + SW'(ad_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    dx_q   <= dx_d;
    aa_q   <= aa_d;
    dd_q   <= dd_d;
    ad_q   <= ad_d;
    adn_q  <= adn_d;
    h2_q   <= h2_d;
    dd2_q  <= dd2_d;
    spos_q <= spos_d;
    sneg_q <= sneg_d;
  end

  // ---------------------------------------------------------------------------------------
  // Segment B. Entry (stage 4) forms the sign and magnitude of A.D and flags a zero axis.
  // Then RTW stages each settle one bit of the axis length and of the apex distance.
  // A stage keeps the remainder n - root^2 and accepts bit b when the remainder covers
  // (root << (b+1)) + 2^(2b).
  // ---------------------------------------------------------------------------------------
  logic [SW-1:0]  b_hrem_d [RTW+1], b_drem_d [RTW+1], b_smag_d [RTW+1], b_dd2_d [RTW+1];
  logic [RTW-1:0] b_hroot_d [RTW+1], b_droot_d [RTW+1];
  logic           b_neg_d [RTW+1], b_degen_d [RTW+1];
  logic [SW-1:0]  b_hrem_q [RTW+1], b_drem_q [RTW+1], b_smag_q [RTW+1], b_dd2_q [RTW+1];
  logic [RTW-1:0] b_hroot_q [RTW+1], b_droot_q [RTW+1];
  logic           b_neg_q [RTW+1], b_degen_q [RTW+1];

  always_comb begin
    logic [SW:0]  th, td;
    int unsigned  bb;
    b_neg_d[0]   = spos_q < sneg_q;
    b_smag_d[0]  = b_neg_d[0] ? (sneg_q - spos_q) : (spos_q - sneg_q);
    b_degen_d[0] = (h2_q == '0);
    b_dd2_d[0]   = dd2_q;
    b_hrem_d[0]  = h2_q;
    b_drem_d[0]  = dd2_q;
    b_hroot_d[0] = '0;
    b_droot_d[0] = '0;
    for (int k = 1; k <= int'(RTW); k++) begin
      bb = RTW - k;
      th = ((SW+1)'(b_hroot_q[k-1]) << (bb + 1)) | ((SW+1)'(1) << (2 * bb));
      td = ((SW+1)'(b_droot_q[k-1]) << (bb + 1)) | ((SW+1)'(1) << (2 * bb));
      if ({1'b0, b_hrem_q[k-1]} >= th) begin
        b_hrem_d[k]  = b_hrem_q[k-1] - SW'(th);
        b_hroot_d[k] = b_hroot_q[k-1] | (RTW'(1) << bb);
      end else begin
        b_hrem_d[k]  = b_hrem_q[k-1];
        b_hroot_d[k] = b_hroot_q[k-1];
      end
      if ({1'b0, b_drem_q[k-1]} >= td) begin
        b_drem_d[k]  = b_drem_q[k-1] - SW'(td);
        b_droot_d[k] = b_droot_q[k-1] | (RTW'(1) << bb);
      end else begin
        b_drem_d[k]  = b_drem_q[k-1];
        b_droot_d[k] = b_droot_q[k-1];
      end
      b_smag_d[k]  = b_smag_q[k-1];
      b_neg_d[k]   = b_neg_q[k-1];
      b_dd2_d[k]   = b_dd2_q[k-1];
      b_degen_d[k] = b_degen_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    b_hrem_q  <= b_hrem_d;
    b_drem_q  <= b_drem_d;
    b_smag_q  <= b_smag_d;
    b_dd2_q   <= b_dd2_d;
    b_hroot_q <= b_hroot_d;
    b_droot_q <= b_droot_d;
    b_neg_q   <= b_neg_d;
    b_degen_q <= b_degen_d;
  end

  // The apex distance saturates only when the root can exceed the 32-bit field.
  logic [DATA_W-1:0] dist_sat;

  if (RTW > DATA_W) begin : g_dist_sat
    assign dist_sat = (|b_droot_q[RTW][RTW-1:DATA_W]) ? '1 : b_droot_q[RTW][DATA_W-1:0];
  end else begin : g_dist_fit
    assign dist_sat = DATA_W'(b_droot_q[RTW]);
  end

  // ---------------------------------------------------------------------------------------
  // M1: height * (height + 1). The projection floor(|s| / height) stays at or below the
  // height exactly when |s| is below this product, so the range check needs no wide
  // quotient and the divider only has to produce RTW bits.
  // ---------------------------------------------------------------------------------------
  logic [SW:0]        m1_hh_q;
  logic [SW-1:0]      m1_smag_q, m1_dd2_q;
  logic [RTW-1:0]     m1_height_q;
  logic               m1_neg_q, m1_degen_q;
  logic [DATA_W-1:0]  m1_dist_q;

  always_ff @(posedge clk_i) begin
    m1_hh_q     <= (SW+1)'(b_hroot_q[RTW]) * ((SW+1)'(b_hroot_q[RTW]) + (SW+1)'(1));
    m1_smag_q   <= b_smag_q[RTW];
    m1_dd2_q    <= b_dd2_q[RTW];
    m1_height_q <= b_hroot_q[RTW];
    m1_neg_q    <= b_neg_q[RTW];
    m1_degen_q  <= b_degen_q[RTW];
    m1_dist_q   <= dist_sat;
  end

  // ---------------------------------------------------------------------------------------
  // Segment C: restoring division |s| / height, one quotient bit per stage, MSB first.
  // Entry (M2) performs the range compare. A quotient is only used when it is in range.
  // ---------------------------------------------------------------------------------------
  logic [SW-1:0]     c_rem_d [RTW+1], c_dd2_d [RTW+1];
  logic [RTW-1:0]    c_quo_d [RTW+1], c_height_d [RTW+1];
  logic              c_big_d [RTW+1], c_neg_d [RTW+1], c_degen_d [RTW+1];
  logic [DATA_W-1:0] c_dist_d [RTW+1];
  logic [SW-1:0]     c_rem_q [RTW+1], c_dd2_q [RTW+1];
  logic [RTW-1:0]    c_quo_q [RTW+1], c_height_q [RTW+1];
  logic              c_big_q [RTW+1], c_neg_q [RTW+1], c_degen_q [RTW+1];
  logic [DATA_W-1:0] c_dist_q [RTW+1];

  always_comb begin
    logic [SW:0] tc;
    int unsigned bc;
    c_rem_d[0]    = m1_smag_q;
    c_quo_d[0]    = '0;
    c_big_d[0]    = {1'b0, m1_smag_q} >= m1_hh_q;
    c_height_d[0] = m1_height_q;
    c_neg_d[0]    = m1_neg_q;
    c_dd2_d[0]    = m1_dd2_q;
    c_degen_d[0]  = m1_degen_q;
    c_dist_d[0]   = m1_dist_q;
    for (int k = 1; k <= int'(RTW); k++) begin
      bc = RTW - k;
      tc = (SW+1)'(c_height_q[k-1]) << bc;
      if ({1'b0, c_rem_q[k-1]} >= tc) begin
        c_rem_d[k] = c_rem_q[k-1] - SW'(tc);
        c_quo_d[k] = c_quo_q[k-1] | (RTW'(1) << bc);
      end else begin
        c_rem_d[k] = c_rem_q[k-1];
        c_quo_d[k] = c_quo_q[k-1];
      end
      c_big_d[k]    = c_big_q[k-1];
      c_height_d[k] = c_height_q[k-1];
      c_neg_d[k]    = c_neg_q[k-1];
      c_dd2_d[k]    = c_dd2_q[k-1];
      c_degen_d[k]  = c_degen_q[k-1];
      c_dist_d[k]   = c_dist_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    c_rem_q    <= c_rem_d;
    c_quo_q    <= c_quo_d;
    c_big_q    <= c_big_d;
    c_height_q <= c_height_d;
    c_neg_q    <= c_neg_d;
    c_dd2_q    <= c_dd2_d;
    c_degen_q  <= c_degen_d;
    c_dist_q   <= c_dist_d;
  end

  // ---------------------------------------------------------------------------------------
  // M3: reject decision, proj^2 and proj * |radius difference|. A negative dot product
  // that still truncates to a zero projection counts as sitting on the apex plane.
  // ---------------------------------------------------------------------------------------
  logic [RTW-1:0]    proj;
  logic              dneg;
  logic [RAD_W-1:0]  dmag;
  logic [QW-1:0]     m3_prod_q;
  logic [SW-1:0]     m3_p2_q, m3_dd2_q;
  logic [RTW-1:0]    m3_height_q;
  logic              m3_reject_q, m3_dneg_q, m3_degen_q;
  logic [DATA_W-1:0] m3_dist_q;

  always_comb begin
    proj = c_quo_q[RTW];
    dneg = rad_b_q < rad_a_q;
    dmag = dneg ? (rad_a_q - rad_b_q) : (rad_b_q - rad_a_q);
  end

  always_ff @(posedge clk_i) begin
    m3_prod_q   <= QW'(proj) * QW'(dmag);
    m3_p2_q     <= SW'(proj) * SW'(proj);
    m3_dd2_q    <= c_dd2_q[RTW];
    m3_height_q <= c_height_q[RTW];
    m3_reject_q <= c_big_q[RTW] | c_degen_q[RTW] | (c_neg_q[RTW] & (proj != '0));
    m3_dneg_q   <= dneg;
    m3_degen_q  <= c_degen_q[RTW];
    m3_dist_q   <= c_dist_q[RTW];
  end

  // ---------------------------------------------------------------------------------------
  // Segment D. Entry (M4) forms the squared distance from the axis, clamped at zero.
  // The following LD stages run its square root and the radius-interpolation divider side
  // by side; each chain is aligned to the end of the segment and passes data before its
  // first bit.
  // ---------------------------------------------------------------------------------------
  logic [RW2-1:0]    d_drem_d [LD+1];
  logic [RAD_W-1:0]  d_quo_d [LD+1];
  logic [SW-1:0]     d_srem_d [LD+1];
  logic [RTW-1:0]    d_sroot_d [LD+1], d_height_d [LD+1];
  logic              d_reject_d [LD+1], d_dneg_d [LD+1], d_degen_d [LD+1];
  logic [DATA_W-1:0] d_dist_d [LD+1];
  logic [RW2-1:0]    d_drem_q [LD+1];
  logic [RAD_W-1:0]  d_quo_q [LD+1];
  logic [SW-1:0]     d_srem_q [LD+1];
  logic [RTW-1:0]    d_sroot_q [LD+1], d_height_q [LD+1];
  logic              d_reject_q [LD+1], d_dneg_q [LD+1], d_degen_q [LD+1];
  logic [DATA_W-1:0] d_dist_q [LD+1];

  always_comb begin
    logic [SW:0]  ts;
    logic [RW2:0] tq;
    int unsigned  bd;
    d_drem_d[0]   = RW2'(m3_prod_q);
    d_quo_d[0]    = '0;
    d_srem_d[0]   = (m3_dd2_q > m3_p2_q) ? (m3_dd2_q - m3_p2_q) : '0;
    d_sroot_d[0]  = '0;
    d_height_d[0] = m3_height_q;
    d_reject_d[0] = m3_reject_q;
    d_dneg_d[0]   = m3_dneg_q;
    d_degen_d[0]  = m3_degen_q;
    d_dist_d[0]   = m3_dist_q;
    for (int k = 1; k <= int'(LD); k++) begin
      bd = LD - k;
      ts = ((SW+1)'(d_sroot_q[k-1]) << (bd + 1)) | ((SW+1)'(1) << (2 * bd));
      tq = (RW2+1)'(d_height_q[k-1]) << bd;
      d_srem_d[k]  = d_srem_q[k-1];
      d_sroot_d[k] = d_sroot_q[k-1];
      d_drem_d[k]  = d_drem_q[k-1];
      d_quo_d[k]   = d_quo_q[k-1];
      if ((bd < RTW) && ({1'b0, d_srem_q[k-1]} >= ts)) begin
        d_srem_d[k]  = d_srem_q[k-1] - SW'(ts);
        d_sroot_d[k] = d_sroot_q[k-1] | (RTW'(1) << bd);
      end
      if ((bd < RAD_W) && ({1'b0, d_drem_q[k-1]} >= tq)) begin
        d_drem_d[k] = d_drem_q[k-1] - RW2'(tq);
        d_quo_d[k]  = d_quo_q[k-1] | (RAD_W'(1) << bd);
      end
      d_height_d[k] = d_height_q[k-1];
      d_reject_d[k] = d_reject_q[k-1];
      d_dneg_d[k]   = d_dneg_q[k-1];
      d_degen_d[k]  = d_degen_q[k-1];
      d_dist_d[k]   = d_dist_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    d_drem_q   <= d_drem_d;
    d_quo_q    <= d_quo_d;
    d_srem_q   <= d_srem_d;
    d_sroot_q  <= d_sroot_d;
    d_height_q <= d_height_d;
    d_reject_q <= d_reject_d;
    d_dneg_q   <= d_dneg_d;
    d_degen_q  <= d_degen_d;
    d_dist_q   <= d_dist_d;
  end

  // ---------------------------------------------------------------------------------------
  // Output stage: radius at the projected height and the final compare. Unless a point is
  // rejected, the quotient is at most the radius difference, so rad_at cannot go negative.
  // ---------------------------------------------------------------------------------------
  logic [RAD_W:0] rad_at;
  logic           inside_d;
  logic           inside_q, degen_q;
  logic [DATA_W-1:0] dist_q;

  always_comb begin
    rad_at = d_dneg_q[LD] ? ({1'b0, rad_a_q} - {1'b0, d_quo_q[LD]})
                          : ({1'b0, rad_a_q} + {1'b0, d_quo_q[LD]});
    inside_d = !d_reject_q[LD] && (XW'(d_sroot_q[LD]) <= XW'(rad_at));
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
    degen_q  <= d_degen_q[LD];
    dist_q   <= d_dist_q[LD];
  end

  assign done_o          = v_q[LAT];
  assign inside_res_o    = inside_q;
  assign apex_distance_o = dist_q;
  assign degenerate_o    = degen_q;

endmodule

@@ hw/rtl/pcft_checker.sv @@
module pcft_checker #(
  parameter int unsigned COORD_WIDTH = pcft_pkg::DEFAULT_COORD_W
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic inside_res_o,
  input logic degenerate_o
);

  localparam int unsigned CB  = (COORD_WIDTH < pcft_pkg::DATA_W) ? COORD_WIDTH
                                                                  : pcft_pkg::DATA_W;
  localparam int unsigned RTW = CB + 1;
  localparam int unsigned LD  = (RTW > pcft_pkg::RAD_W) ? RTW : pcft_pkg::RAD_W;
  localparam int unsigned LAT = 9 + 2 * RTW + LD;

  // Every accepted beat produces its result after the fixed pipeline latency.
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted point produced no result at the expected cycle");

  // No result appears without a beat accepted the pipeline latency earlier.
  a_result_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without a matching accepted point");

  // A zero-length axis always rejects the point.
  a_degenerate_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> !inside_res_o)
    else $error("degenerate cone reported a point as inside");

endmodule

bind point_in_cone_frustum_test pcft_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pcft_checker (.*);

@@ tb/sv/tb_point_in_cone_frustum_test.sv @@
module tb_point_in_cone_frustum_test;
  timeunit 1ns;
  timeprecision 1ps;

  // PIPE_LAT is the block's latency at the default width; settle() idles for it plus a
  // margin after the last result.
  localparam int unsigned PIPE_LAT = 108;
  localparam int unsigned SETTLE_CYC = PIPE_LAT + 16;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PTS_PER_PHASE = 250;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct packed {
    logic        inside_res;
    logic [31:0] apex_dist;
    logic        degen;
  } cone_res_t;

  typedef enum logic {ROW_CFG, ROW_PT} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    pcft_pkg::cfg_idx_e idx;
    logic [31:0]        data;
    logic [31:0]        px;
    logic [31:0]        py;
    logic [31:0]        pz;
    logic               chk;
    cone_res_t          res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic signed [pcft_pkg::DATA_W-1:0] point_x_i = '0;
  logic signed [pcft_pkg::DATA_W-1:0] point_y_i = '0;
  logic signed [pcft_pkg::DATA_W-1:0] point_z_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [pcft_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pcft_pkg::DATA_W-1:0] cfg_wdata_i = '0;
  logic        done_o;
  logic        inside_res_o;
  logic [pcft_pkg::DATA_W-1:0] apex_distance_o;
  logic        degenerate_o;

  point_in_cone_frustum_test dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .point_x_i, .point_y_i, .point_z_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .done_o, .inside_res_o, .apex_distance_o, .degenerate_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Our own copy of the cone held in the block's registers.
  logic signed [31:0] cone_apex [3];
  logic signed [31:0] cone_base [3];
  logic [30:0] apex_rad, base_rad;

  // Results predicted for accepted points, oldest first.
  cone_res_t pending_res [$];
  int unsigned err_cnt = 0;
  // Typed-in expectations from the directed table, matched by arrival order.
  logic      typed_chk [$];
  cone_res_t typed_res [$];

  // Integer square root, floored, of a value up to 128 bits.
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0] acc;
    logic [63:0] cand;
    acc = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = acc | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) acc = cand;
    end
    return acc;
  endfunction

  function automatic logic [127:0] mag(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // Frustum test in exact wide integers. Every quotient truncates toward zero and every root
  // floors, matching the block's bit-serial arithmetic.
  function automatic cone_res_t frustum_check(logic signed [31:0] px, logic signed [31:0] py,
                                              logic signed [31:0] pz);
    cone_res_t   res;
    longint      ax, dx, ra, rb, delta, r;
    logic [127:0] h2, dd2, spos, sneg, t, smag, qw, p2, rad2;
    logic [63:0] dist_root, height, proj, q, axd;
    logic signed [31:0] pt [3];
    logic        neg;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    h2 = '0; dd2 = '0; spos = '0; sneg = '0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      ax = longint'(cone_base[i]) - longint'(cone_apex[i]);
      dx = longint'(pt[i]) - longint'(cone_apex[i]);
      h2 += mag(ax) * mag(ax);
      dd2 += mag(dx) * mag(dx);
      t = mag(ax) * mag(dx);
      if ((ax < 0) != (dx < 0)) sneg += t;
      else spos += t;
    end
    dist_root = floor_root(dd2);
    res.apex_dist = (dist_root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dist_root[31:0];
    if (h2 == 0) begin
      res.degen = 1'b1;
    end else begin
      height = floor_root(h2);
      neg = spos < sneg;
      smag = neg ? sneg - spos : spos - sneg;
      qw = smag / {64'd0, height};
      proj = (qw[127:64] != 0) ? '1 : qw[63:0];
      // A negative projection that truncates to zero still counts as the apex plane.
      if (!(neg && proj != 0) && proj <= height) begin
        ra = longint'(apex_rad);
        rb = longint'(base_rad);
        delta = rb - ra;
        qw = ({64'd0, proj} * mag(delta)) / {64'd0, height};
        q = (qw[127:64] != 0) ? '1 : qw[63:0];
        r = (delta < 0) ? ra - longint'(q) : ra + longint'(q);
        p2 = {64'd0, proj} * {64'd0, proj};
        rad2 = (dd2 > p2) ? dd2 - p2 : '0;
        axd = floor_root(rad2);
        if (r >= 0 && axd <= 64'(r)) res.inside_res = 1'b1;
      end
    end
    return res;
  endfunction

  // Register writes and accepted points are both observed at the rising edge, the same edge
  // at which the block takes them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cone_apex[i] <= '0;
        cone_base[i] <= '0;
      end
      apex_rad <= '0;
      base_rad <= '0;
    end else if (cfg_we_i) begin
      case (pcft_pkg::cfg_idx_e'(cfg_idx_i))
        pcft_pkg::CFG_APEX_X:      cone_apex[0] <= cfg_wdata_i;
        pcft_pkg::CFG_APEX_Y:      cone_apex[1] <= cfg_wdata_i;
        pcft_pkg::CFG_APEX_Z:      cone_apex[2] <= cfg_wdata_i;
        pcft_pkg::CFG_BASE_X:      cone_base[0] <= cfg_wdata_i;
        pcft_pkg::CFG_BASE_Y:      cone_base[1] <= cfg_wdata_i;
        pcft_pkg::CFG_BASE_Z:      cone_base[2] <= cfg_wdata_i;
        pcft_pkg::CFG_APEX_RADIUS: apex_rad <= cfg_wdata_i[30:0];
        pcft_pkg::CFG_BASE_RADIUS: base_rad <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // Scoreboard. Each result beat is compared against the oldest prediction, and where the
  // directed table typed in a value, against that too.
  always @(posedge clk_i) begin
    cone_res_t want, typed;
    logic      has_typed;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        pending_res = {pending_res, frustum_check(point_x_i, point_y_i, point_z_i)};
      end
      if (done_o) begin
        if (pending_res.size() == 0) begin
          $error("result beat with no point outstanding");
          err_cnt++;
        end else begin
          want = pending_res.pop_front();
          has_typed = 1'b0;
          typed = '0;
          if (typed_chk.size() != 0) begin
            has_typed = typed_chk.pop_front();
            typed = typed_res.pop_front();
          end
          if (has_typed && typed != want) begin
            $error("typed expectation %p disagrees with prediction %p", typed, want);
            err_cnt++;
          end
          if (inside_res_o !== want.inside_res) begin
            $error("inside_res: expected %0d, got %0d", want.inside_res, inside_res_o);
            err_cnt++;
          end
          if (apex_distance_o !== want.apex_dist) begin
            $error("apex_distance: expected %h, got %h", want.apex_dist, apex_distance_o);
            err_cnt++;
          end
          if (degenerate_o !== want.degen) begin
            $error("degenerate: expected %0d, got %0d", want.degen, degenerate_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // Inputs change only at the falling edge, so nothing races the sampling edge.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    @(negedge clk_i);
    start_i = 1'b1;
    point_x_i = x;
    point_y_i = y;
    point_z_i = z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic idle_for(int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drop start, wait until every predicted result has arrived, then let the pipe empty.
  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(pcft_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Most gaps are short; a few are long enough to drain a good part of the pipe.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Cone shapes for a random phase: anything at all, a small well-scaled cone where points
  // land inside often, or coordinates pinned to the extremes.
  task automatic random_cone();
    int unsigned shape;
    logic [31:0] v;
    shape = $urandom_range(0, 2);
    for (int i = 0; i < 6; i++) begin
      case (shape)
        0: v = $urandom;
        1: v = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        default: v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      write_reg(pcft_pkg::cfg_idx_e'(i), v);
    end
    case (shape)
      1: begin
        write_reg(pcft_pkg::CFG_APEX_RADIUS, $urandom_range(0, 32'h0008_0000));
        write_reg(pcft_pkg::CFG_BASE_RADIUS, $urandom_range(0, 32'h0008_0000));
      end
      default: begin
        write_reg(pcft_pkg::CFG_APEX_RADIUS,
                  ($urandom_range(0, 1) != 0) ? $urandom : 32'h7FFF_FFFF);
        write_reg(pcft_pkg::CFG_BASE_RADIUS,
                  ($urandom_range(0, 1) != 0) ? $urandom : 32'h0);
      end
    endcase
  endtask

  // Points mostly along the axis, from a bit before the apex to a bit past the base, offset
  // by up to about the larger radius; the rest are full-range noise or points near the apex.
  task automatic random_point(output logic [31:0] x, output logic [31:0] y,
                              output logic [31:0] z);
    int unsigned pick;
    longint tpos, span, off, ax;
    logic [31:0] c [3];
    pick = $urandom_range(0, 99);
    tpos = longint'($urandom_range(0, 1100)) - 50;
    span = (apex_rad > base_rad) ? longint'(apex_rad) : longint'(base_rad);
    for (int i = 0; i < 3; i++) begin
      if (pick < 65) begin
        ax = longint'(cone_base[i]) - longint'(cone_apex[i]);
        off = longint'($urandom) % (span + 1);
        if ($urandom_range(0, 1) != 0) off = -off;
        c[i] = 32'(longint'(cone_apex[i]) + (ax * tpos) / 1000 + off);
      end else if (pick < 85) begin
        c[i] = $urandom;
      end else begin
        c[i] = 32'(longint'(cone_apex[i]) + longint'($urandom_range(0, 8)) - 4);
      end
    end
    x = c[0];
    y = c[1];
    z = c[2];
  endtask

  // Directed table. Config rows are applied only with the block idle. Point rows carry a
  // typed result where it can be read off directly: with every register at reset the axis has
  // zero length, and with the apex at the most negative corner and the point at the most
  // positive one the distance saturates.
  dir_row_t dir_tbl [24] = '{
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
      '{1'b0, 32'h0, 1'b1}},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, ONE, 32'h0, 32'h0, 1'b1, '{1'b0, ONE, 1'b1}},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'h0, -ONE, 32'h0, 1'b1, '{1'b0, ONE, 1'b1}},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_X, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_Y, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_Z, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      '{1'b0, 32'hFFFF_FFFF, 1'b0}},
    '{ROW_CFG, pcft_pkg::CFG_APEX_X, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_Y, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_Z, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_BASE_X, 32'h000A_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_RADIUS, ONE, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_BASE_RADIUS, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'h0005_0000, 32'h0002_0000, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, -ONE, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'h000A_0000, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0, 32'h000A_0001, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_APEX_RADIUS, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_CFG, pcft_pkg::CFG_BASE_RADIUS, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_PT,  pcft_pkg::CFG_APEX_X, 32'h0,
      32'h0005_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0}
  };

  initial begin
    logic [31:0] x, y, z;
    logic        no_gaps;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < $size(dir_tbl); i++) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        if (i == 0 || dir_tbl[i-1].kind != ROW_CFG) settle();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        typed_chk = {typed_chk, dir_tbl[i].chk};
        typed_res = {typed_res, dir_tbl[i].res};
        send_point(dir_tbl[i].px, dir_tbl[i].py, dir_tbl[i].pz);
        idle_for(gap_len());
      end
    end

    // Random phases. Each one starts from an idle block, which also makes the sender wait
    // for every outstanding result; every third phase runs back to back with no gaps.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      random_cone();
      no_gaps = (ph % 3 == 2);
      for (int n = 0; n < PTS_PER_PHASE; n++) begin
        random_point(x, y, z);
        send_point(x, y, z);
        if (!no_gaps) idle_for(gap_len());
      end
    end

    settle();
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The worst case finishes well before this cap, which stops a hung run.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
